FILE: design/two_way_transposition_table_macros.svh
// assertion macros for the transposition table checker
`ifndef TWO_WAY_TRANSPOSITION_TABLE_MACROS_SVH
`define TWO_WAY_TRANSPOSITION_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TWTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TWTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/twtt_pkg.sv
// types, constants and helpers shared by the transposition table files
package twtt_pkg;

    localparam int INDEX_BITS = 12;
    localparam int ROW_BITS   = INDEX_BITS - 1;
    localparam int ROWS       = 1 << ROW_BITS;

    localparam logic [7:0] MOVE_NONE = 8'd44;

    typedef enum logic [1:0] {
        FN_STORE1 = 2'd0,
        FN_STORE4 = 2'd1,
        FN_PROBE  = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_TRANS_LOW  = 3'd0,
        CFG_TRANS_HIGH = 3'd1,
        CFG_TABLE_BITS = 3'd2,
        CFG_EXACT_MASK = 3'd3,
        CFG_MISS_EVAL  = 3'd4,
        CFG_MISS_DEPTH = 3'd5,
        CFG_MISS_FLAGS = 3'd6,
        CFG_UNUSED     = 3'd7
    } t_cfg_index;

    typedef struct packed {
        t_func              func;
        logic [31:0]        code_low;
        logic [31:0]        code_high;
        logic               swap_halves;
        logic signed [31:0] score;
        logic [7:0]         bound_flags;
        logic [7:0]         search_depth;
        logic [7:0]         selectivity;
        logic [7:0]         move0;
        logic [7:0]         move1;
        logic [7:0]         move2;
        logic [7:0]         move3;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic               written;
        logic [7:0]         out_key_high;
        logic [31:0]        out_key_tag;
        logic signed [31:0] out_eval;
        logic [7:0]         out_flags;
        logic [7:0]         out_depth;
        logic [7:0]         out_selectivity;
        logic [7:0]         out_move0;
        logic [7:0]         out_move1;
        logic [7:0]         out_move2;
        logic [7:0]         out_move3;
    } t_result;

    // one 128-bit table entry
    typedef struct packed {
        logic [7:0]  key_high;
        logic [31:0] key2;
        logic [31:0] eval;
        logic [7:0]  mv0;
        logic [7:0]  mv1;
        logic [7:0]  mv2;
        logic [7:0]  mv3;
        logic [7:0]  sel;
        logic [7:0]  flags;
        logic [7:0]  depth;
    } t_entry;

    // index mask for the clamped table size
    function automatic logic [INDEX_BITS-1:0] active_mask(input logic [3:0] tb);
        int unsigned ab;
        if (tb == 4'd0) begin
            ab = 1;
        end else if (int'(tb) > INDEX_BITS) begin
            ab = INDEX_BITS;
        end else begin
            ab = int'(tb);
        end
        return ~({INDEX_BITS{1'b1}} << ab);
    endfunction

endpackage

FILE: design/two_way_transposition_table.sv
// two-way transposition table with depth-preferred replacement
//
// usage
//   command channel: an item is taken at a clock edge with start high and
//   busy low. func selects store one move, store four moves, probe or
//   clear depths. every item gives exactly one result on o_result, marked
//   by o_done for a single cycle; the receiver cannot stall, so the result
//   must be taken in that cycle.
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; ready is always high, a transfer writes one register, an
//   unknown index is dropped. write config only while the block is idle.
// timing
//   probe and store: slots i and i^1 sit in an even and an odd bank at
//   the same row, so one read cycle fetches both, then the chosen bank
//   is written back as the result registers load. the next item can
//   start the cycle o_done is high.
//   clear depths: one table row per cycle, a read-modify-write walk over
//   the two bank ports.
// reset
//   i_rst_n is synchronous. after reset a clearing pass zeroes all
//   2^(INDEX_BITS-1) rows, one per cycle, with busy high; config
//   transfers are taken during that pass.
module two_way_transposition_table (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  twtt_pkg::t_item         i_item,
    output logic                    o_done,
    output twtt_pkg::t_result       o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  twtt_pkg::t_cfg_index    i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_CLR
    } t_state;

    // control and registered outputs
    t_state                          r_state;
    logic [twtt_pkg::ROW_BITS-1:0]   r_row;
    logic                            r_done;
    twtt_pkg::t_result               r_result;

    // item held through the lookup cycle
    twtt_pkg::t_item                 r_item;
    logic [31:0]                     r_code1;
    logic [31:0]                     r_code2;
    logic                            r_bank;

    // configuration registers
    logic [31:0]                     r_trans_low;
    logic [31:0]                     r_trans_high;
    logic [3:0]                      r_table_bits;
    logic [7:0]                      r_exact_mask;
    logic signed [31:0]              r_miss_eval;
    logic [7:0]                      r_miss_depth;
    logic [7:0]                      r_miss_flags;

    // even and odd slot banks
    twtt_pkg::t_entry                mem_even [twtt_pkg::ROWS];
    twtt_pkg::t_entry                mem_odd  [twtt_pkg::ROWS];
    twtt_pkg::t_entry                r_rd_even;
    twtt_pkg::t_entry                r_rd_odd;

    logic [twtt_pkg::ROW_BITS-1:0]   rd_row;
    logic [twtt_pkg::ROW_BITS-1:0]   wr_row;
    logic                            we_even;
    logic                            we_odd;
    twtt_pkg::t_entry                wd_even;
    twtt_pkg::t_entry                wd_odd;

    logic [twtt_pkg::INDEX_BITS-1:0] mask;
    logic [twtt_pkg::ROW_BITS-1:0]   last_row;
    logic [31:0]                     in_code1;
    logic [31:0]                     in_code2;
    logic [twtt_pkg::INDEX_BITS-1:0] in_index;
    logic                            accept;

    // lookup decision
    twtt_pkg::t_entry                e_i;
    twtt_pkg::t_entry                e_p;
    twtt_pkg::t_entry                e_sel;
    twtt_pkg::t_entry                e_hit;
    twtt_pkg::t_entry                new_entry;
    logic                            key_i;
    logic                            key_p;
    logic                            hit_i;
    logic                            hit_p;
    logic                            pick_i;
    logic                            pick_key;
    logic [9:0]                      limit;
    logic                            do_write;
    logic                            wr_bank;
    twtt_pkg::t_result               n_result;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    assign mask     = twtt_pkg::active_mask(r_table_bits);
    assign last_row = mask[twtt_pkg::INDEX_BITS-1:1];

    // hash words after optional swap and transform masks
    assign in_code1 = i_item.swap_halves ? (i_item.code_high ^ r_trans_high)
                                         : (i_item.code_low ^ r_trans_low);
    assign in_code2 = i_item.swap_halves ? (i_item.code_low ^ r_trans_low)
                                         : (i_item.code_high ^ r_trans_high);
    assign in_index = in_code1[twtt_pkg::INDEX_BITS-1:0] & mask;

    // slot i and its partner from the two banks
    assign e_i = r_bank ? r_rd_odd : r_rd_even;
    assign e_p = r_bank ? r_rd_even : r_rd_odd;

    assign key_i = (e_i.key2 == r_code2);
    assign key_p = (e_p.key2 == r_code2);
    // a tag match on slot i with a wrong top byte blocks the partner
    assign hit_i = key_i && (e_i.key_high == r_code1[31:24]);
    assign hit_p = !key_i && key_p && (e_p.key_high == r_code1[31:24]);
    assign e_hit = hit_i ? e_i : e_p;

    // store: tag match first, else the shallower slot
    assign pick_i   = key_i || (!key_p && (e_i.depth <= e_p.depth));
    assign e_sel    = pick_i ? e_i : e_p;
    assign pick_key = pick_i ? key_i : key_p;
    assign limit    = {2'b00, r_item.search_depth}
                    + (((r_item.bound_flags & r_exact_mask) != 8'd0) ? 10'd2 : 10'd0)
                    + (pick_key ? 10'd2 : 10'd4);
    assign do_write = (r_item.func != twtt_pkg::FN_PROBE)
                   && ({2'b00, e_sel.depth} <= limit);
    assign wr_bank  = pick_i ? r_bank : ~r_bank;

    always_comb begin
        new_entry          = '0;
        new_entry.key_high = r_code1[31:24];
        new_entry.key2     = r_code2;
        new_entry.eval     = r_item.score;
        new_entry.flags    = r_item.bound_flags;
        new_entry.depth    = r_item.search_depth;
        new_entry.sel      = r_item.selectivity;
        new_entry.mv0      = r_item.move0;
        if (r_item.func == twtt_pkg::FN_STORE4) begin
            new_entry.mv1 = r_item.move1;
            new_entry.mv2 = r_item.move2;
            new_entry.mv3 = r_item.move3;
        end
    end

    // result of a probe or store
    always_comb begin
        n_result = '0;
        if (r_item.func == twtt_pkg::FN_PROBE) begin
            if (hit_i || hit_p) begin
                n_result.hit             = 1'b1;
                n_result.out_key_high    = e_hit.key_high;
                n_result.out_key_tag     = e_hit.key2;
                n_result.out_eval        = e_hit.eval;
                n_result.out_flags       = e_hit.flags;
                n_result.out_depth       = e_hit.depth;
                n_result.out_selectivity = e_hit.sel;
                n_result.out_move0       = e_hit.mv0;
                n_result.out_move1       = e_hit.mv1;
                n_result.out_move2       = e_hit.mv2;
                n_result.out_move3       = e_hit.mv3;
            end else begin
                n_result.out_eval  = r_miss_eval;
                n_result.out_flags = r_miss_flags;
                n_result.out_depth = r_miss_depth;
                n_result.out_move0 = twtt_pkg::MOVE_NONE;
            end
        end else begin
            n_result.written = do_write;
        end
    end

    // memory port steering
    always_comb begin
        rd_row  = r_row;
        wr_row  = r_row;
        we_even = 1'b0;
        we_odd  = 1'b0;
        wd_even = new_entry;
        wd_odd  = new_entry;
        case (r_state)
            S_INIT: begin
                // zero every row after reset
                we_even = 1'b1;
                we_odd  = 1'b1;
                wd_even = '0;
                wd_odd  = '0;
            end
            S_IDLE: begin
                // a clear walks from row zero, other items fetch their row pair
                if (i_item.func == twtt_pkg::FN_CLEAR) begin
                    rd_row = '0;
                end else begin
                    rd_row = in_index[twtt_pkg::INDEX_BITS-1:1];
                end
            end
            S_LOOK: begin
                we_even = do_write && !wr_bank;
                we_odd  = do_write && wr_bank;
            end
            S_CLR: begin
                // write back the row read last cycle with depth zeroed, fetch the next
                rd_row        = r_row + 1'b1;
                we_even       = 1'b1;
                we_odd        = 1'b1;
                wd_even       = r_rd_even;
                wd_odd        = r_rd_odd;
                wd_even.depth = 8'd0;
                wd_odd.depth  = 8'd0;
            end
            default: begin
                rd_row = r_row;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_even) begin
            mem_even[wr_row] <= wd_even;
        end
        r_rd_even <= mem_even[rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (we_odd) begin
            mem_odd[wr_row] <= wd_odd;
        end
        r_rd_odd <= mem_odd[rd_row];
    end

    // configuration transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_low  <= 32'd0;
            r_trans_high <= 32'd0;
            r_table_bits <= 4'd12;
            r_exact_mask <= 8'd4;
            r_miss_eval  <= 32'sd12345678;
            r_miss_depth <= 8'd0;
            r_miss_flags <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                twtt_pkg::CFG_TRANS_LOW:  r_trans_low  <= i_cfg_data;
                twtt_pkg::CFG_TRANS_HIGH: r_trans_high <= i_cfg_data;
                twtt_pkg::CFG_TABLE_BITS: r_table_bits <= i_cfg_data[3:0];
                twtt_pkg::CFG_EXACT_MASK: r_exact_mask <= i_cfg_data[7:0];
                twtt_pkg::CFG_MISS_EVAL:  r_miss_eval  <= i_cfg_data;
                twtt_pkg::CFG_MISS_DEPTH: r_miss_depth <= i_cfg_data[7:0];
                twtt_pkg::CFG_MISS_FLAGS: r_miss_flags <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // item capture, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_item;
            r_code1 <= in_code1;
            r_code2 <= in_code2;
            r_bank  <= in_index[0];
        end
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_row    <= '0;
            r_done   <= 1'b0;
            r_result <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == {twtt_pkg::ROW_BITS{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.func == twtt_pkg::FN_CLEAR) begin
                            r_row   <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_row   <= in_index[twtt_pkg::INDEX_BITS-1:1];
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_done   <= 1'b1;
                    r_result <= n_result;
                    r_state  <= S_IDLE;
                end
                S_CLR: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == last_row) begin
                        r_done   <= 1'b1;
                        r_result <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/twtt_checker.sv
// port-level checker for the transposition table, bound to the top level
`include "two_way_transposition_table_macros.svh"

module twtt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input twtt_pkg::t_result o_result
);

    // a result never lands in the cycle right after the command transfer
    `TWTT_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, start && !busy, busy && !o_done, "early done")

    // results are single-cycle strobes, never back to back
    `TWTT_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "repeated strobe")

    // the block is ready for a new command when a result is shown
    `TWTT_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")

    // a probe hit never reports a write
    `TWTT_ASSERT_NOW(a_hit_only, i_clk, i_rst_n, o_result.hit, !o_result.written, "hit written")

endmodule

bind two_way_transposition_table twtt_checker u_twtt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

FILE: sim/tb_two_way_transposition_table.sv
// testbench for the two-way transposition table: directed cases, then random traffic
`timescale 1ns / 100ps

module tb_two_way_transposition_table;

    localparam int WATCHDOG_LIMIT = 25000;  // covers the reset clearing pass and a full clear
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 197;
    localparam int POOL_SIZE      = 12;
    localparam int REPORT_LIMIT   = 10;

    // dut ports, inputs all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    twtt_pkg::t_item      i_item      = '0;
    logic                 o_done;
    twtt_pkg::t_result    o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    twtt_pkg::t_cfg_index i_cfg_index = twtt_pkg::CFG_TRANS_LOW;
    logic [31:0]          i_cfg_data  = '0;

    // shadow copy of the table and its registers, reset values
    twtt_pkg::t_entry table_model [0:(1 << twtt_pkg::INDEX_BITS) - 1];
    logic [31:0] m_trans_low  = 32'd0;
    logic [31:0] m_trans_high = 32'd0;
    logic [3:0]  m_table_bits = 4'd12;
    logic [7:0]  m_exact_mask = 8'd4;
    logic [31:0] m_miss_eval  = 32'd12345678;
    logic [7:0]  m_miss_depth = 8'd0;
    logic [7:0]  m_miss_flags = 8'd1;

    // answers predicted at each command transfer, oldest first
    twtt_pkg::t_result pending_answers [$];

    // positions reused by the random traffic so that slots collide
    logic [31:0] pool_code1 [POOL_SIZE];
    logic [31:0] pool_code2 [POOL_SIZE];

    bit          gaps_on    = 1'b1;
    int unsigned quiet_left = 0;
    int          stall_cycles = 0;

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned reg_writes     = 0;
    int unsigned settings_used  = 0;
    int unsigned probe_hits     = 0;
    int unsigned probe_misses   = 0;
    int unsigned stores_written = 0;
    int unsigned stores_refused = 0;
    int unsigned depth_clears   = 0;

    two_way_transposition_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // expected answer for one command, updating the shadow table as the block would
    function automatic twtt_pkg::t_result lookup_and_update(input twtt_pkg::t_item it);
        logic [31:0]       c1;
        logic [31:0]       c2;
        logic [7:0]        kh;
        int unsigned       eff;
        int unsigned       msk;
        int unsigned       i1;
        int unsigned       i2;
        int unsigned       idx;
        int unsigned       lim;
        int unsigned       n;
        bit                found;
        twtt_pkg::t_entry  e;
        twtt_pkg::t_result r;
        r = '0;
        found = 1'b0;
        if (it.swap_halves) begin
            c1 = it.code_high ^ m_trans_high;
            c2 = it.code_low ^ m_trans_low;
        end else begin
            c1 = it.code_low ^ m_trans_low;
            c2 = it.code_high ^ m_trans_high;
        end
        // table size clamps to 1 .. INDEX_BITS
        eff = 32'(m_table_bits);
        if (eff < 1) eff = 1;
        if (eff > twtt_pkg::INDEX_BITS) eff = twtt_pkg::INDEX_BITS;
        msk = (1 << eff) - 1;
        i1 = c1 & msk;
        i2 = i1 ^ 1;
        kh = c1[31:24];
        case (it.func)
            twtt_pkg::FN_CLEAR: begin
                // only depths of slots in use are zeroed
                for (n = 0; n <= msk; n++) table_model[n].depth = 8'd0;
                depth_clears++;
            end
            twtt_pkg::FN_PROBE: begin
                // a tag match with the wrong top byte in slot i blocks the partner
                if (table_model[i1].key2 == c2) begin
                    if (table_model[i1].key_high == kh) begin
                        e = table_model[i1];
                        found = 1'b1;
                    end
                end else if (table_model[i2].key2 == c2 && table_model[i2].key_high == kh) begin
                    e = table_model[i2];
                    found = 1'b1;
                end
                if (found) begin
                    r.hit             = 1'b1;
                    r.out_key_high    = e.key_high;
                    r.out_key_tag     = e.key2;
                    r.out_eval        = e.eval;
                    r.out_flags       = e.flags;
                    r.out_depth       = e.depth;
                    r.out_selectivity = e.sel;
                    r.out_move0       = e.mv0;
                    r.out_move1       = e.mv1;
                    r.out_move2       = e.mv2;
                    r.out_move3       = e.mv3;
                    probe_hits++;
                end else begin
                    r.out_eval  = m_miss_eval;
                    r.out_flags = m_miss_flags;
                    r.out_depth = m_miss_depth;
                    r.out_move0 = twtt_pkg::MOVE_NONE;
                    probe_misses++;
                end
            end
            default: begin
                // tag match first, else the shallower slot, slot i on a tie
                if (table_model[i1].key2 == c2) idx = i1;
                else if (table_model[i2].key2 == c2) idx = i2;
                else idx = (table_model[i1].depth <= table_model[i2].depth) ? i1 : i2;
                e = table_model[idx];
                lim = 32'(it.search_depth);
                if ((it.bound_flags & m_exact_mask) != 8'd0) lim += 2;
                lim += (e.key2 == c2) ? 2 : 4;
                if (32'(e.depth) > lim) begin
                    stores_refused++;
                end else begin
                    table_model[idx] = '{
                        key_high: kh,
                        key2:     c2,
                        eval:     it.score,
                        mv0:      it.move0,
                        mv1:      (it.func == twtt_pkg::FN_STORE4) ? it.move1 : 8'd0,
                        mv2:      (it.func == twtt_pkg::FN_STORE4) ? it.move2 : 8'd0,
                        mv3:      (it.func == twtt_pkg::FN_STORE4) ? it.move3 : 8'd0,
                        sel:      it.selectivity,
                        flags:    it.bound_flags,
                        depth:    it.search_depth
                    };
                    r.written = 1'b1;
                    stores_written++;
                end
            end
        endcase
        return r;
    endfunction

    // command for a given code pair, random payload, hash words built back through the masks
    function automatic twtt_pkg::t_item hashed_item(input twtt_pkg::t_func f,
                                                    input logic [31:0] c1,
                                                    input logic [31:0] c2);
        twtt_pkg::t_item it;
        it.func = f;
        it.swap_halves = 1'($urandom);
        if (it.swap_halves) begin
            it.code_high = c1 ^ m_trans_high;
            it.code_low  = c2 ^ m_trans_low;
        end else begin
            it.code_low  = c1 ^ m_trans_low;
            it.code_high = c2 ^ m_trans_high;
        end
        it.score        = $urandom;
        it.bound_flags  = 8'($urandom);
        it.search_depth = 8'($urandom);
        it.selectivity  = 8'($urandom);
        it.move0        = 8'($urandom);
        it.move1        = 8'($urandom);
        it.move2        = 8'($urandom);
        it.move3        = 8'($urandom);
        return it;
    endfunction

    // mostly pool positions and their near misses, some plain noise
    function automatic twtt_pkg::t_item random_item();
        logic [31:0]     c1;
        logic [31:0]     c2;
        int unsigned     pick;
        int unsigned     roll;
        int unsigned     clear_pct;
        twtt_pkg::t_func f;
        twtt_pkg::t_item it;
        pick = $urandom_range(0, POOL_SIZE - 1);
        c1 = pool_code1[pick];
        c2 = pool_code2[pick];
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            c1 = $urandom;
            c2 = $urandom;
        end else if (roll < 35) begin
            c1[31:24] = 8'($urandom);   // same slot and tag, other top byte
        end else if (roll < 45) begin
            c1[0] = ~c1[0];             // partner slot
        end
        // clears walk the whole table, keep them rare when it is large
        clear_pct = (m_table_bits >= 4'd1 && m_table_bits <= 4'd6) ? 5 : 1;
        roll = $urandom_range(0, 99);
        if (roll < clear_pct) f = twtt_pkg::FN_CLEAR;
        else if (roll < 45) f = twtt_pkg::FN_PROBE;
        else if (roll < 72) f = twtt_pkg::FN_STORE4;
        else f = twtt_pkg::FN_STORE1;
        it = hashed_item(f, c1, c2);
        // depths near each other so the replacement margins matter
        roll = $urandom_range(0, 99);
        if (roll < 60) it.search_depth = 8'($urandom_range(0, 12));
        else if (roll < 75) it.search_depth = 8'($urandom_range(248, 255));
        return it;
    endfunction

    // one command transfer, with random idle bursts ahead of it
    task automatic send_item(input twtt_pkg::t_item it);
        int unsigned gap;
        if (quiet_left > 0) begin
            quiet_left--;
        end else if (gaps_on) begin
            if ($urandom_range(0, 9) == 0) begin
                quiet_left = $urandom_range(10, 40);
            end else if ($urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 10);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_answers.push_back(lookup_and_update(it));
        items_sent++;
    endtask

    // drain every answer and let the block fall idle
    task automatic settle();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register transfer; valid is left high for the next write
    task automatic write_reg(input twtt_pkg::t_cfg_index idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            twtt_pkg::CFG_TRANS_LOW:  m_trans_low  = data;
            twtt_pkg::CFG_TRANS_HIGH: m_trans_high = data;
            twtt_pkg::CFG_TABLE_BITS: m_table_bits = data[3:0];
            twtt_pkg::CFG_EXACT_MASK: m_exact_mask = data[7:0];
            twtt_pkg::CFG_MISS_EVAL:  m_miss_eval  = data;
            twtt_pkg::CFG_MISS_DEPTH: m_miss_depth = data[7:0];
            twtt_pkg::CFG_MISS_FLAGS: m_miss_flags = data[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // write every register, narrow ones with junk in the unused upper bits
    task automatic configure(input logic [3:0] tbits, input logic [31:0] lo_mask,
                             input logic [31:0] hi_mask, input logic [7:0] exact,
                             input logic [31:0] ev_miss, input logic [7:0] dp_miss,
                             input logic [7:0] fl_miss);
        write_reg(twtt_pkg::CFG_TRANS_LOW, lo_mask);
        write_reg(twtt_pkg::CFG_TRANS_HIGH, hi_mask);
        write_reg(twtt_pkg::CFG_TABLE_BITS, {28'($urandom), tbits});
        write_reg(twtt_pkg::CFG_EXACT_MASK, {24'($urandom), exact});
        write_reg(twtt_pkg::CFG_MISS_EVAL, ev_miss);
        write_reg(twtt_pkg::CFG_MISS_DEPTH, {24'($urandom), dp_miss});
        write_reg(twtt_pkg::CFG_MISS_FLAGS, {24'($urandom), fl_miss});
        // unknown index must not disturb anything
        write_reg(twtt_pkg::CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // fresh entries hold tag 0 and top byte 0
    task automatic test_zeroed_table();
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h0000_0005, 32'h0000_0000));
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h8000_0004, 32'h0000_0000));
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h1234_5678, 32'hFFFF_FFFF));
    endtask

    // field extremes through a store and back out of a probe
    task automatic test_store_and_probe();
        twtt_pkg::t_item it;
        it = hashed_item(twtt_pkg::FN_STORE4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        it.score        = 32'h8000_0000;
        it.bound_flags  = 8'hFF;
        it.search_depth = 8'hFF;
        it.selectivity  = 8'hFF;
        it.move0        = 8'hFF;
        it.move1        = 8'hFF;
        it.move2        = 8'hFF;
        it.move3        = 8'hFF;
        send_item(it);
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // single-move store drops moves one to three
        it = hashed_item(twtt_pkg::FN_STORE1, 32'h0000_0020, 32'h1234_5678);
        it.score        = 32'h7FFF_FFFF;
        it.bound_flags  = 8'h00;
        it.search_depth = 8'h00;
        it.selectivity  = 8'h00;
        it.move0        = 8'hAA;
        it.move1        = 8'hAA;
        it.move2        = 8'hAA;
        it.move3        = 8'hAA;
        send_item(it);
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h0000_0020, 32'h1234_5678));
    endtask

    // second store lands in the partner slot, probe finds it there
    task automatic test_partner_slot();
        twtt_pkg::t_item it;
        it = hashed_item(twtt_pkg::FN_STORE4, 32'h1100_0040, 32'hA5A5_0001);
        it.search_depth = 8'd10;
        send_item(it);
        it = hashed_item(twtt_pkg::FN_STORE4, 32'h2200_0040, 32'h5A5A_0002);
        it.search_depth = 8'd5;
        send_item(it);
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h2200_0040, 32'h5A5A_0002));
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h3300_0040, 32'hA5A5_0001));
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h1100_0041, 32'hA5A5_0001));
    endtask

    // tag match with a wrong top byte in slot i hides a full match in slot i^1
    task automatic test_blocked_partner();
        twtt_pkg::t_item it;
        it = hashed_item(twtt_pkg::FN_STORE1, 32'h7700_0050, 32'h0000_0000);
        it.search_depth = 8'd3;
        send_item(it);
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h0000_0050, 32'h0000_0000));
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h0000_0051, 32'h0000_0000));
    endtask

    // depth replacement margins, exact-score bonus, same-tag margin
    task automatic test_replacement();
        twtt_pkg::t_item it;
        it = hashed_item(twtt_pkg::FN_STORE4, 32'h0100_0060, 32'hC000_0001);
        it.search_depth = 8'd30;
        it.bound_flags  = 8'h00;
        send_item(it);
        it = hashed_item(twtt_pkg::FN_STORE4, 32'h0200_0060, 32'hC000_0002);
        it.search_depth = 8'd40;
        it.bound_flags  = 8'h00;
        send_item(it);
        // shallower slot holds 30: 23+4 refused, 23+2+4 refused, 24+2+4 taken
        it = hashed_item(twtt_pkg::FN_STORE4, 32'h0300_0060, 32'hC000_0003);
        it.search_depth = 8'd23;
        it.bound_flags  = 8'h00;
        send_item(it);
        it.bound_flags  = 8'h04;
        send_item(it);
        it.search_depth = 8'd24;
        send_item(it);
        // same tag holds 40: 37+2 refused, 38+2 taken
        it = hashed_item(twtt_pkg::FN_STORE1, 32'h0200_0060, 32'hC000_0002);
        it.search_depth = 8'd37;
        it.bound_flags  = 8'h00;
        send_item(it);
        it.search_depth = 8'd38;
        send_item(it);
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h0200_0060, 32'hC000_0002));
    endtask

    // depths go to zero, everything else stays
    task automatic test_clear_depths();
        send_item(hashed_item(twtt_pkg::FN_CLEAR, $urandom, $urandom));
        send_item(hashed_item(twtt_pkg::FN_PROBE, 32'h0200_0060, 32'hC000_0002));
        settle();
    endtask

    // random traffic under a series of register settings, extremes first
    task automatic test_random_traffic();
        int unsigned p;
        int unsigned k;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(4'd1, 32'h0, 32'h0, 8'h04, 32'h8000_0000, 8'hFF, 8'hFF);
                1: configure(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF,
                             8'h00, 8'h00);
                2: configure(4'd15, $urandom, $urandom, 8'h00, $urandom,
                             8'($urandom), 8'($urandom));
                3: configure(4'd2, $urandom, $urandom, 8'($urandom), $urandom,
                             8'($urandom), 8'($urandom));
                default: configure(4'($urandom_range(1, 6)), $urandom, $urandom,
                                   8'($urandom), $urandom, 8'($urandom), 8'($urandom));
            endcase
            // a few indexes per phase so stores and probes keep meeting
            for (k = 0; k < POOL_SIZE; k++) begin
                pool_code1[k] = {8'($urandom), 12'($urandom), 12'($urandom_range(0, 7))};
                pool_code2[k] = (k > 0 && $urandom_range(0, 4) == 0) ? pool_code2[k - 1]
                                                                      : $urandom;
            end
            // one position that matches never-written entries
            pool_code1[0][31:24] = 8'h00;
            pool_code2[0] = 32'h0;
            gaps_on = (p != PHASES - 1);
            quiet_left = 0;
            for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
            settle();
        end
    endtask

    // every answer against the oldest prediction, results cannot be held off
    always @(posedge i_clk) begin : answer_check
        twtt_pkg::t_result want;
        string             diffs;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result with nothing pending: %h", o_result);
            end else begin
                want = pending_answers.pop_front();
                diffs = "";
                if (o_result.hit !== want.hit) diffs = {diffs, " hit"};
                if (o_result.written !== want.written) diffs = {diffs, " written"};
                if (o_result.out_key_high !== want.out_key_high) diffs = {diffs, " key_high"};
                if (o_result.out_key_tag !== want.out_key_tag) diffs = {diffs, " key_tag"};
                if (o_result.out_eval !== want.out_eval) diffs = {diffs, " eval"};
                if (o_result.out_flags !== want.out_flags) diffs = {diffs, " flags"};
                if (o_result.out_depth !== want.out_depth) diffs = {diffs, " depth"};
                if (o_result.out_selectivity !== want.out_selectivity)
                    diffs = {diffs, " selectivity"};
                if (o_result.out_move0 !== want.out_move0) diffs = {diffs, " move0"};
                if (o_result.out_move1 !== want.out_move1) diffs = {diffs, " move1"};
                if (o_result.out_move2 !== want.out_move2) diffs = {diffs, " move2"};
                if (o_result.out_move3 !== want.out_move3) diffs = {diffs, " move3"};
                if (diffs != "") begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch in%s: expected %h, got %h", diffs, want, o_result);
                end
            end
        end
    end

    // watchdog: any transfer or result restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("no progress for %0d cycles", stall_cycles);
            $display("[two_way_transposition_table] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (table_model[n]) table_model[n] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // commands wait out the clearing pass through busy
        test_zeroed_table();
        test_store_and_probe();
        test_partner_slot();
        test_blocked_partner();
        test_replacement();
        test_clear_depths();
        test_random_traffic();
        if (pending_answers.size() != 0) mismatch_count++;
        $display("%0d commands under %0d register settings plus reset values, %0d writes",
                 items_sent, settings_used, reg_writes);
        $display("probes %0d hit %0d missed, stores %0d written %0d refused, %0d clears",
                 probe_hits, probe_misses, stores_written, stores_refused, depth_clears);
        if (mismatch_count == 0) begin
            $display("[two_way_transposition_table] OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[two_way_transposition_table] ERROR");
        end
        $finish;
    end

endmodule
